### design/nfha_pkg.sv
// Package for the next-fit heap allocator.
// Item types, field widths, status and action codes, parameter defaults.
// No dependencies.
`default_nettype none

package nfha_pkg;

    localparam int HEAP_UNITS_DEF = 4096;
    localparam int UNIT_BYTES_DEF = 8;

    localparam int ADDR_W   = 12;
    localparam int BYTES_W  = 16;
    localparam int STATUS_W = 2;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OOM  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO = 2'd2;

    typedef struct packed {
        logic               action;
        logic [BYTES_W-1:0] byte_count;
        logic [ADDR_W-1:0]  block_address;
    } t_req;

    typedef struct packed {
        logic [ADDR_W-1:0]   granted_address;
        logic [STATUS_W-1:0] status;
    } t_rsp;

endpackage

`default_nettype wire

### design/next_fit_heap_allocator_top.sv
// Flow: unit rounding and dispatch, then a walk of the free list with a header read and
// then a compare for each entry visited, then the split or merge writes; a zero size item
// skips the walk, and a full result register holds the item until it drains.
// Throughput: one item at a time; the header memory port sets the walk rate.
// Reset: synchronous, active low; the INIT state that follows reset writes the initial free block.
// Next-fit allocator over an address-ordered free list with coalescing.
// Uses nfha_pkg. Holds the header memory and one shared add/subtract unit.
`default_nettype none

module next_fit_heap_allocator_top #(
    parameter int HEAP_UNITS = nfha_pkg::HEAP_UNITS_DEF,
    parameter int UNIT_BYTES = nfha_pkg::UNIT_BYTES_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_req_valid,
    output logic                o_req_ready,
    input  wire nfha_pkg::t_req i_req,
    output logic                o_rsp_valid,
    input  wire logic           i_rsp_ready,
    output nfha_pkg::t_rsp      o_rsp
);

    localparam int AW  = $clog2(HEAP_UNITS);
    localparam int DW  = nfha_pkg::BYTES_W + 1;
    localparam int CW  = (AW + 1 > DW) ? AW + 1 : DW;
    localparam int HW  = 2 * AW;
    localparam int RSH = DW + 5;
    localparam int RW  = RSH - 1;
    localparam logic [RW-1:0] RECIP = RW'(((1 << RSH) + UNIT_BYTES - 1) / UNIT_BYTES);

    localparam logic [4:0] S_INIT    = 5'd0;
    localparam logic [4:0] S_IDLE    = 5'd1;
    localparam logic [4:0] S_DIV     = 5'd2;
    localparam logic [4:0] S_DISP    = 5'd3;
    localparam logic [4:0] S_A_START = 5'd4;
    localparam logic [4:0] S_A_RQ    = 5'd5;
    localparam logic [4:0] S_A_RD    = 5'd6;
    localparam logic [4:0] S_A_CMP   = 5'd7;
    localparam logic [4:0] S_A_SPLIT = 5'd8;
    localparam logic [4:0] S_SETQ    = 5'd9;
    localparam logic [4:0] S_F_CHK   = 5'd10;
    localparam logic [4:0] S_F_CHK2  = 5'd11;
    localparam logic [4:0] S_F_RD    = 5'd12;
    localparam logic [4:0] S_F_CMP   = 5'd13;
    localparam logic [4:0] S_F_DEC   = 5'd14;
    localparam logic [4:0] S_F_QEND  = 5'd15;
    localparam logic [4:0] S_F_QCHK  = 5'd16;
    localparam logic [4:0] S_F_TOT   = 5'd17;
    localparam logic [4:0] S_F_WR    = 5'd18;
    localparam logic [4:0] S_DONE    = 5'd19;

    // header memory: {link, size}
    logic [HW-1:0] r_hdr_mem [HEAP_UNITS];
    logic [HW-1:0] r_rdata;

    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [HW-1:0] wr_data;
    logic [AW-1:0] rd_link, rd_size;

    logic [CW-1:0] u_a, u_b;
    logic          u_sub;
    logic [CW:0]   u_res;

    logic [4:0]              r_state, n_state;
    logic                    r_act, n_act;
    logic [CW-1:0]           r_addr, n_addr;
    logic [DW-1:0]           r_dvd, n_dvd;
    logic [AW-1:0]           r_q, n_q;
    logic [AW-1:0]           r_qsize, n_qsize;
    logic [AW-1:0]           r_p, n_p;
    logic [AW-1:0]           r_plink, n_plink;
    logic [AW-1:0]           r_psize, n_psize;
    logic                    r_pass, n_pass;
    logic [CW-1:0]           r_rend, n_rend;
    logic [CW-1:0]           r_tmp, n_tmp;
    logic                    r_mrg_p, n_mrg_p;
    logic                    r_mrg_q, n_mrg_q;
    logic [AW-1:0]           r_lnkval, n_lnkval;
    logic [AW-1:0]           r_grant, n_grant;
    logic [nfha_pkg::STATUS_W-1:0] r_status, n_status;
    logic [AW-1:0]           r_head, n_head;
    logic [AW-1:0]           r_rover, n_rover;
    logic                    r_out_valid, n_out_valid;
    nfha_pkg::t_rsp          r_out, n_out;

    logic [DW+RW-1:0] div_prod;
    logic [CW-1:0]    grant_ext;

    assign rd_link = r_rdata[HW-1:AW];
    assign rd_size = r_rdata[AW-1:0];

    // shared add/subtract unit; u_res[CW] is carry (no borrow on subtract)
    assign u_res = {1'b0, u_a} + {1'b0, (u_sub ? ~u_b : u_b)} + {{CW{1'b0}}, u_sub};

    // round-up division by the unit size as a reciprocal multiply
    assign div_prod  = r_dvd * RECIP;
    assign grant_ext = CW'(r_grant);

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_hdr_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_hdr_mem[rd_addr];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_act       = r_act;
        n_addr      = r_addr;
        n_dvd       = r_dvd;
        n_q         = r_q;
        n_qsize     = r_qsize;
        n_p         = r_p;
        n_plink     = r_plink;
        n_psize     = r_psize;
        n_pass      = r_pass;
        n_rend      = r_rend;
        n_tmp       = r_tmp;
        n_mrg_p     = r_mrg_p;
        n_mrg_q     = r_mrg_q;
        n_lnkval    = r_lnkval;
        n_grant     = r_grant;
        n_status    = r_status;
        n_head      = r_head;
        n_rover     = r_rover;
        n_out_valid = r_out_valid && !i_rsp_ready;
        n_out       = r_out;
        rd_en       = 1'b0;
        rd_addr     = r_p;
        wr_en       = 1'b0;
        wr_addr     = r_q;
        wr_data     = '0;
        u_a         = '0;
        u_b         = '0;
        u_sub       = 1'b0;

        case (r_state)
            S_INIT: begin
                wr_en   = 1'b1;
                wr_addr = AW'(1);
                wr_data = {AW'(0), AW'(HEAP_UNITS - 1)};
                n_state = S_IDLE;
            end
            S_IDLE: begin
                u_a = CW'(i_req.byte_count);
                u_b = CW'(UNIT_BYTES - 1);
                if (i_req_valid) begin
                    n_act    = i_req.action;
                    n_addr   = CW'(i_req.block_address);
                    n_dvd    = u_res[DW-1:0];
                    n_grant  = '0;
                    n_status = nfha_pkg::ST_OK;
                    n_state  = S_DIV;
                end
            end
            S_DIV: begin
                n_dvd   = DW'(div_prod[DW+RW-1:RSH]);
                n_state = S_DISP;
            end
            S_DISP: begin
                if (r_dvd == '0) begin
                    n_status = nfha_pkg::ST_ZERO;
                    n_state  = S_DONE;
                end else if (r_act == nfha_pkg::ACT_ALLOC) begin
                    n_state = S_A_START;
                end else begin
                    n_state = S_F_CHK;
                end
            end
            S_A_START: begin
                n_q    = r_rover;
                n_pass = 1'b0;
                if (r_rover == '0) begin
                    n_qsize = '0;
                    n_p     = r_head;
                    n_state = S_A_RD;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_rover;
                    n_state = S_A_RQ;
                end
            end
            S_A_RQ: begin
                n_qsize = rd_size;
                n_p     = rd_link;
                n_state = S_A_RD;
            end
            S_A_RD: begin
                if (r_p == '0) begin
                    if (!r_pass) begin
                        n_pass  = 1'b1;
                        n_q     = '0;
                        n_qsize = '0;
                        n_p     = r_head;
                    end else begin
                        n_status = nfha_pkg::ST_OOM;
                        n_state  = S_DONE;
                    end
                end else begin
                    rd_en   = 1'b1;
                    n_state = S_A_CMP;
                end
            end
            S_A_CMP: begin
                u_a     = CW'(rd_size);
                u_b     = CW'(r_dvd);
                u_sub   = 1'b1;
                n_plink = rd_link;
                if (!u_res[CW]) begin
                    n_q     = r_p;
                    n_qsize = rd_size;
                    n_p     = rd_link;
                    n_state = S_A_RD;
                end else begin
                    n_grant = r_p;
                    n_tmp   = u_res[CW-1:0];
                    if (u_res[CW-1:0] == '0) begin
                        n_lnkval = rd_link;
                        n_rover  = rd_link;
                        n_state  = S_SETQ;
                    end else begin
                        n_state = S_A_SPLIT;
                    end
                end
            end
            S_A_SPLIT: begin
                // remainder block starts right after the granted front part
                u_a      = CW'(r_p);
                u_b      = CW'(r_dvd);
                wr_en    = 1'b1;
                wr_addr  = u_res[AW-1:0];
                wr_data  = {r_plink, r_tmp[AW-1:0]};
                n_lnkval = u_res[AW-1:0];
                n_rover  = u_res[AW-1:0];
                n_state  = S_SETQ;
            end
            S_SETQ: begin
                if (r_q == '0) begin
                    n_head = r_lnkval;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = r_q;
                    wr_data = {r_lnkval, r_qsize};
                end
                n_state = S_DONE;
            end
            S_F_CHK: begin
                u_a     = r_addr;
                u_b     = CW'(r_dvd);
                n_rend  = u_res[CW-1:0];
                n_state = S_F_CHK2;
            end
            S_F_CHK2: begin
                if (r_addr == '0 || r_rend > CW'(HEAP_UNITS)) begin
                    n_state = S_DONE;
                end else begin
                    n_q     = '0;
                    n_qsize = '0;
                    n_p     = r_head;
                    n_state = S_F_RD;
                end
            end
            S_F_RD: begin
                if (r_p == '0) begin
                    n_state = S_F_DEC;
                end else begin
                    rd_en   = 1'b1;
                    n_state = S_F_CMP;
                end
            end
            S_F_CMP: begin
                u_a   = CW'(r_p);
                u_b   = r_addr;
                u_sub = 1'b1;
                if (!u_res[CW]) begin
                    n_q     = r_p;
                    n_qsize = rd_size;
                    n_p     = rd_link;
                    n_state = S_F_RD;
                end else begin
                    n_plink = rd_link;
                    n_psize = rd_size;
                    n_state = S_F_DEC;
                end
            end
            S_F_DEC: begin
                // successor overlap and abut test
                u_a     = CW'(r_p);
                u_b     = r_rend;
                u_sub   = 1'b1;
                n_mrg_p = (r_p != '0) && u_res[CW] && (u_res[CW-1:0] == '0);
                if (r_p != '0 && !u_res[CW]) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_F_QEND;
                end
            end
            S_F_QEND: begin
                u_a     = CW'(r_q);
                u_b     = CW'(r_qsize);
                n_tmp   = u_res[CW-1:0];
                n_state = S_F_QCHK;
            end
            S_F_QCHK: begin
                // predecessor overlap and abut test
                u_a     = r_addr;
                u_b     = r_tmp;
                u_sub   = 1'b1;
                n_mrg_q = (r_q != '0) && (u_res[CW-1:0] == '0);
                if (r_q != '0 && !u_res[CW]) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_F_TOT;
                end
            end
            S_F_TOT: begin
                u_a = CW'(r_dvd);
                u_b = CW'(r_psize);
                if (r_mrg_p) begin
                    n_tmp = u_res[CW-1:0];
                end else begin
                    n_tmp   = CW'(r_dvd);
                    n_plink = r_p;
                end
                n_state = S_F_WR;
            end
            S_F_WR: begin
                u_a     = CW'(r_qsize);
                u_b     = r_tmp;
                n_rover = r_q;
                wr_en   = 1'b1;
                if (r_mrg_q) begin
                    wr_addr = r_q;
                    wr_data = {r_plink, u_res[AW-1:0]};
                    n_state = S_DONE;
                end else begin
                    wr_addr  = r_addr[AW-1:0];
                    wr_data  = {r_plink, r_tmp[AW-1:0]};
                    n_lnkval = r_addr[AW-1:0];
                    n_state  = S_SETQ;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_rsp_ready) begin
                    n_out.granted_address = grant_ext[nfha_pkg::ADDR_W-1:0];
                    n_out.status          = r_status;
                    n_out_valid           = 1'b1;
                    n_state               = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_head      <= AW'(1);
            r_rover     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_rover     <= n_rover;
            r_out_valid <= n_out_valid;
        end
        r_act    <= n_act;
        r_addr   <= n_addr;
        r_dvd    <= n_dvd;
        r_q      <= n_q;
        r_qsize  <= n_qsize;
        r_p      <= n_p;
        r_plink  <= n_plink;
        r_psize  <= n_psize;
        r_pass   <= n_pass;
        r_rend   <= n_rend;
        r_tmp    <= n_tmp;
        r_mrg_p  <= n_mrg_p;
        r_mrg_q  <= n_mrg_q;
        r_lnkval <= n_lnkval;
        r_grant  <= n_grant;
        r_status <= n_status;
        r_out    <= n_out;
    end

endmodule

`default_nettype wire

### design/nfha_checker.sv
// Port-level checker for the next-fit heap allocator, bound to the top level.
// Uses nfha_pkg.
`default_nettype none

module nfha_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_req_valid,
    input wire logic           o_req_ready,
    input wire logic           o_rsp_valid,
    input wire logic           i_rsp_ready,
    input wire nfha_pkg::t_rsp o_rsp
);

    logic [1:0] r_pend;
    logic       req_acc, rsp_acc;

    assign req_acc = i_req_valid && o_req_ready;
    assign rsp_acc = o_rsp_valid && i_rsp_ready;

    // items accepted whose results are not yet taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + {1'b0, req_acc} - {1'b0, rsp_acc};
        end
    end

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_rsp))
        else $error("result item changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> (o_rsp.status == nfha_pkg::ST_OK ||
                         o_rsp.status == nfha_pkg::ST_OOM ||
                         o_rsp.status == nfha_pkg::ST_ZERO))
        else $error("undefined status");

    a_fail_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.status != nfha_pkg::ST_OK |-> o_rsp.granted_address == '0)
        else $error("address given on failed item");

    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> r_pend != '0)
        else $error("result item without request");

    a_pend_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend != 2'd3)
        else $error("too many items in flight");

endmodule

bind next_fit_heap_allocator_top nfha_checker u_nfha_checker (.*);

`default_nettype wire
